@@ design/awt_pkg.sv @@
// ----------------------------------------------------------------------------
// awt_pkg: shared types and constants of the word tokenizer
// Field widths, byte codes, configuration indexes, and the record types that
// pass between the gather side, the word queue and the emit side.
// ----------------------------------------------------------------------------
`default_nettype none

package awt_pkg;

	localparam int BYTE_W    = 8;
	localparam int POS_W     = 6;
	localparam int WNUM_W    = 32;
	localparam int SNUM_W    = 16;
	localparam int CFG_IDX_W = 1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_KEEP_LONG   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SPACE_DELIM = 1'd1;

	// Byte codes
	localparam logic [BYTE_W-1:0] CH_DOT      = 8'h2E;
	localparam logic [BYTE_W-1:0] CH_DASH     = 8'h2D;
	localparam logic [BYTE_W-1:0] CH_SPACE    = 8'h20;
	localparam logic [BYTE_W-1:0] CH_TAB      = 8'h09;
	localparam logic [BYTE_W-1:0] CH_CR       = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_DIGIT_0  = 8'h30;
	localparam logic [BYTE_W-1:0] CH_DIGIT_9  = 8'h39;
	localparam logic [BYTE_W-1:0] CH_UPPER_A  = 8'h41;
	localparam logic [BYTE_W-1:0] CH_UPPER_Z  = 8'h5A;
	localparam logic [BYTE_W-1:0] CH_LOWER_A  = 8'h61;
	localparam logic [BYTE_W-1:0] CH_LOWER_Z  = 8'h7A;
	localparam logic [BYTE_W-1:0] CASE_OFFSET = 8'h20;

	typedef struct packed {
		logic keep_long;
		logic space_delim;
	} cfg_t;

	// One finished word waiting in the buffer bank it was gathered into
	typedef struct packed {
		logic              bank;
		logic [POS_W-1:0]  len;
		logic [WNUM_W-1:0] word_num;
		logic [SNUM_W-1:0] seg_num;
	} desc_t;

	// One emitted character
	typedef struct packed {
		logic [BYTE_W-1:0] ch;
		logic [POS_W-1:0]  pos;
		logic              last;
		logic [WNUM_W-1:0] word_num;
		logic [SNUM_W-1:0] seg_num;
	} result_t;

	function automatic logic is_alnum(input logic [BYTE_W-1:0] b);
		return (b >= CH_DIGIT_0 && b <= CH_DIGIT_9) ||
			(b >= CH_UPPER_A && b <= CH_UPPER_Z) ||
			(b >= CH_LOWER_A && b <= CH_LOWER_Z);
	endfunction

	function automatic logic is_space(input logic [BYTE_W-1:0] b);
		return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
	endfunction

	function automatic logic [BYTE_W-1:0] to_lower(input logic [BYTE_W-1:0] b);
		return (b >= CH_UPPER_A && b <= CH_UPPER_Z) ? b + CASE_OFFSET : b;
	endfunction

endpackage

`default_nettype wire

@@ design/awt_ram.sv @@
// ----------------------------------------------------------------------------
// awt_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module awt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

@@ design/awt_front.sv @@
// ----------------------------------------------------------------------------
// awt_front: byte classifier and word gatherer
// Tracks the scan phase, writes lower-cased characters into the current
// buffer bank and hands each finished word to the word queue.
// ----------------------------------------------------------------------------
`default_nettype none

module awt_front #(
	parameter int WORD_CAP = 32
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire awt_pkg::cfg_t                       cfg,
	input  wire logic                                accept,
	input  wire logic [awt_pkg::BYTE_W-1:0]          text_byte,
	input  wire logic                                segment_end,
	output logic                                     wr_en,
	output logic      [$clog2(WORD_CAP):0]           wr_addr,
	output logic      [awt_pkg::BYTE_W-1:0]          wr_data,
	output logic                                     desc_push,
	output awt_pkg::desc_t                           desc
);

	import awt_pkg::*;

	localparam int IW = $clog2(WORD_CAP);
	localparam logic [IW-1:0] LEN_MAX = IW'(WORD_CAP - 1);

	localparam logic [1:0] PH_SKIP   = 2'd0;
	localparam logic [1:0] PH_GATHER = 2'd1;
	localparam logic [1:0] PH_DRAIN  = 2'd2;

	logic [1:0]        phase_q, phase_d;
	logic [IW-1:0]     len_q, len_d;
	logic              dot_q, dot_d;
	logic [WNUM_W-1:0] wcnt_q;
	logic [SNUM_W-1:0] scnt_q;
	logic              bank_q;

	logic          c_alnum, c_space, c_drain, c_gather, c_start, b_dot;
	logic          wr_c, emit_c, em_dot;
	logic [IW-1:0] wr_idx, em_len, trimmed;

	always_comb begin
		c_alnum  = is_alnum(text_byte);
		c_space  = is_space(text_byte);
		b_dot    = (text_byte == CH_DOT);
		c_drain  = c_alnum || b_dot || (text_byte == CH_DASH);
		c_gather = cfg.space_delim ? !c_space : c_drain;
		c_start  = cfg.space_delim ? !c_space : c_alnum;
	end

	always_comb begin
		phase_d = phase_q;
		len_d   = len_q;
		dot_d   = dot_q;
		wr_c    = 1'b0;
		wr_idx  = len_q;
		emit_c  = 1'b0;
		em_len  = len_q;
		em_dot  = dot_q;
		unique case (phase_q)
			PH_GATHER: begin
				if (!c_gather) begin
					emit_c  = 1'b1;
					phase_d = PH_SKIP;
				end else if (len_q == LEN_MAX) begin
					if (c_drain && !segment_end) begin
						phase_d = PH_DRAIN;
					end else begin
						emit_c  = cfg.keep_long;
						phase_d = PH_SKIP;
					end
				end else begin
					wr_c  = 1'b1;
					len_d = len_q + IW'(1);
					dot_d = b_dot;
					if (segment_end) begin
						emit_c  = 1'b1;
						em_len  = len_q + IW'(1);
						em_dot  = b_dot;
						phase_d = PH_SKIP;
					end
				end
			end
			PH_DRAIN: begin
				if (!(c_drain && !segment_end)) begin
					emit_c  = cfg.keep_long;
					phase_d = PH_SKIP;
				end
			end
			default: begin
				phase_d = PH_SKIP;
				if (c_start) begin
					wr_c   = 1'b1;
					wr_idx = '0;
					len_d  = IW'(1);
					dot_d  = b_dot;
					if (segment_end) begin
						emit_c = 1'b1;
						em_len = IW'(1);
						em_dot = b_dot;
					end else begin
						phase_d = PH_GATHER;
					end
				end
			end
		endcase
		if (segment_end) begin
			phase_d = PH_SKIP;
		end
	end

	// drop one trailing dot
	assign trimmed   = em_len - IW'(em_dot);
	assign desc_push = accept && emit_c && (trimmed != '0);

	assign wr_en   = accept && wr_c;
	assign wr_addr = {bank_q, wr_idx};
	assign wr_data = to_lower(text_byte);

	always_comb begin
		desc.bank     = bank_q;
		desc.len      = POS_W'(trimmed);
		desc.word_num = wcnt_q;
		desc.seg_num  = scnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SKIP;
			len_q   <= '0;
			dot_q   <= 1'b0;
			wcnt_q  <= WNUM_W'(1);
			scnt_q  <= '0;
			bank_q  <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_d;
			len_q   <= len_d;
			dot_q   <= dot_d;
			if (desc_push) begin
				bank_q <= !bank_q;
			end
			if (segment_end) begin
				wcnt_q <= WNUM_W'(1);
				scnt_q <= scnt_q + SNUM_W'(1);
			end else if (desc_push && wcnt_q != '1) begin
				wcnt_q <= wcnt_q + WNUM_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

@@ design/awt_word_q.sv @@
// ----------------------------------------------------------------------------
// awt_word_q: two-entry queue of finished words
// One entry per buffer bank; full means both banks hold unread words.
// ----------------------------------------------------------------------------
`default_nettype none

module awt_word_q (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire awt_pkg::desc_t din,
	input  wire logic           pop,
	output awt_pkg::desc_t      dout,
	output logic                full,
	output logic                empty
);

	import awt_pkg::*;

	desc_t      ent_q [2];
	logic       wptr_q, rptr_q;
	logic [1:0] cnt_q;

	assign dout  = ent_q[rptr_q];
	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= !wptr_q;
			end
			if (pop) begin
				rptr_q <= !rptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("word queue pushed while both banks are taken");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("word queue popped while empty");

endmodule

`default_nettype wire

@@ design/awt_back.sv @@
// ----------------------------------------------------------------------------
// awt_back: character emitter
// Walks the oldest queued word through the buffer, one read a cycle while the
// output queue has room, and parks the results in a small output queue.
// ----------------------------------------------------------------------------
`default_nettype none

module awt_back #(
	parameter int WORD_CAP = 32
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           q_empty,
	input  wire awt_pkg::desc_t                 q_head,
	output logic                                q_pop,
	output logic                                rd_en,
	output logic      [$clog2(WORD_CAP):0]      rd_addr,
	input  wire logic [awt_pkg::BYTE_W-1:0]     rd_data,
	input  wire logic                           pop,
	output logic                                empty,
	output awt_pkg::result_t                    res
);

	import awt_pkg::*;

	localparam int IW     = $clog2(WORD_CAP);
	localparam int ODEPTH = 4;
	localparam int OPW    = $clog2(ODEPTH);
	localparam int OCW    = OPW + 1;

	logic [IW-1:0]     pos_q;
	logic              last_c, credit_ok;

	logic              valid_s1;
	logic [POS_W-1:0]  pos_s1;
	logic              last_s1;
	logic [WNUM_W-1:0] wn_s1;
	logic [SNUM_W-1:0] sn_s1;

	result_t           ofifo_q [ODEPTH];
	logic [OPW-1:0]    owp_q, orp_q;
	logic [OCW-1:0]    ocnt_q;
	logic              opush, opop;

	// keep room for the read in flight
	assign credit_ok = (ocnt_q + OCW'(valid_s1)) < OCW'(ODEPTH);
	assign rd_en     = !q_empty && credit_ok;
	assign last_c    = (POS_W'(pos_q) + POS_W'(1)) == q_head.len;
	assign q_pop     = rd_en && last_c;
	assign rd_addr   = {q_head.bank, pos_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= rd_en;
			if (rd_en) begin
				pos_q <= last_c ? '0 : pos_q + IW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			pos_s1  <= POS_W'(pos_q);
			last_s1 <= last_c;
			wn_s1   <= q_head.word_num;
			sn_s1   <= q_head.seg_num;
		end
	end

	assign opush = valid_s1;
	assign opop  = pop && !empty;
	assign empty = (ocnt_q == '0);
	assign res   = ofifo_q[orp_q];

	always_ff @(posedge clk) begin
		if (opush) begin
			ofifo_q[owp_q] <= '{ch: rd_data, pos: pos_s1, last: last_s1,
				word_num: wn_s1, seg_num: sn_s1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owp_q  <= '0;
			orp_q  <= '0;
			ocnt_q <= '0;
		end else begin
			if (opush) begin
				owp_q <= owp_q + OPW'(1);
			end
			if (opop) begin
				orp_q <= orp_q + OPW'(1);
			end
			ocnt_q <= ocnt_q + OCW'(opush) - OCW'(opop);
		end
	end

	a_ocnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ocnt_q <= OCW'(ODEPTH))
		else $error("output queue count beyond depth");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		opush |-> (ocnt_q < OCW'(ODEPTH)) || opop)
		else $error("read data arrived with the output queue full");

endmodule

`default_nettype wire

@@ design/alnum_word_tokenizer.sv @@
// ----------------------------------------------------------------------------
// alnum_word_tokenizer: streaming word tokenizer
// Turns a byte stream into lower-cased words, one character per result.
// ----------------------------------------------------------------------------
// Push one document byte per transaction; raise segment_end on the last byte
// of a segment. The block takes one byte per cycle while full stays low. Each
// finished word is emitted as a run of characters (one per result transaction)
// tagged with its position, a last-character flag, its ordinal within the
// segment and the number of completed segments. Words are gathered into one of
// two buffer banks while the other bank is read out one character per cycle
// while the output queue has room, so emission overlaps with gathering; each
// word goes through the word queue, RAM read and output queue. full rises only
// while two finished words wait in both banks and the older one is not yet
// fully read out, so input stalls only when words arrive faster than their
// characters are drained. Configuration is written through cfg_valid/cfg_ready
// (always ready) and must only change while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module alnum_word_tokenizer #(
	parameter int WORD_CAP = 32
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// byte input
	input  wire logic                              push,
	output logic                                   full,
	input  wire logic [awt_pkg::BYTE_W-1:0]        text_byte,
	input  wire logic                              segment_end,
	// character output
	output logic                                   empty,
	input  wire logic                              pop,
	output logic      [awt_pkg::BYTE_W-1:0]        word_char,
	output logic      [awt_pkg::POS_W-1:0]         char_position,
	output logic                                   last_of_word,
	output logic      [awt_pkg::WNUM_W-1:0]        word_ordinal,
	output logic      [awt_pkg::SNUM_W-1:0]        segment_number,
	// configuration writes
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [awt_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic                              cfg_data
);

	import awt_pkg::*;

	localparam int IW = $clog2(WORD_CAP);

	cfg_t    cfg_q;
	logic    accept;

	// gather side to buffer and queue
	logic          wr_en;
	logic [IW:0]   wr_addr;
	logic [BYTE_W-1:0] wr_data;
	logic          desc_push;
	desc_t         desc_in;

	// queue and buffer to emit side
	desc_t         q_head;
	logic          q_empty, q_full, q_pop;
	logic          rd_en;
	logic [IW:0]   rd_addr;
	logic [BYTE_W-1:0] rd_data;
	result_t       res;

	// Always take configuration writes
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_KEEP_LONG:   cfg_q.keep_long   <= cfg_data;
				REG_SPACE_DELIM: cfg_q.space_delim <= cfg_data;
			endcase
		end
	end

	// Hold input while both buffer banks carry unread words
	assign full   = q_full;
	assign accept = push && !full;

	awt_front #(
		.WORD_CAP(WORD_CAP)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.accept     (accept),
		.text_byte  (text_byte),
		.segment_end(segment_end),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.desc_push  (desc_push),
		.desc       (desc_in)
	);

	// Two banks of word characters, addressed {bank, index}
	awt_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(2 ** (IW + 1))
	) u_buf (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	awt_word_q u_word_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (desc_push),
		.din   (desc_in),
		.pop   (q_pop),
		.dout  (q_head),
		.full  (q_full),
		.empty (q_empty)
	);

	awt_back #(
		.WORD_CAP(WORD_CAP)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_empty(q_empty),
		.q_head (q_head),
		.q_pop  (q_pop),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.pop    (pop),
		.empty  (empty),
		.res    (res)
	);

	// Present the oldest waiting character
	assign word_char      = res.ch;
	assign char_position  = res.pos;
	assign last_of_word   = res.last;
	assign word_ordinal   = res.word_num;
	assign segment_number = res.seg_num;

endmodule

`default_nettype wire

@@ tb/tb_alnum_word_tokenizer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_alnum_word_tokenizer: self-checking bench of the streaming word tokenizer
// Push document bytes through the input queue port and predict every emitted
// character with an in-bench tokenizer. Compare each popped character, field
// by field, against the oldest prediction. The stimulus starts with a short
// directed table and continues with random phases under every register
// setting.
// ----------------------------------------------------------------------------

module tb_alnum_word_tokenizer;
	import awt_pkg::*;

	localparam int WORD_CAP         = 32;
	localparam int BUF_LEN          = WORD_CAP - 1;
	localparam int RAND_PHASES      = 6;
	localparam int RAND_PHASE_ITEMS = 24;
	// first character passes the word queue, RAM read and output queue; keep margin
	localparam int SETTLE_CYCLES    = 8;
	localparam logic [WNUM_W-1:0] WNUM_MAX = '1;

	typedef enum logic [1:0] {
		SCAN_SKIP,
		SCAN_GATHER,
		SCAN_DRAIN
	} scan_e;

	// How a directed row is checked: by the predictor, by a typed value, or as giving no character
	typedef enum logic [1:0] {
		CHK_MODEL,
		CHK_NONE,
		CHK_ONE
	} row_chk_e;

	typedef struct {
		logic              cfg_set;
		logic              keep;
		logic              spc;
		logic [BYTE_W-1:0] b;
		logic              e;
		row_chk_e          chk;
		logic [BYTE_W-1:0] ch;
		logic [WNUM_W-1:0] wnum;
		logic [SNUM_W-1:0] snum;
	} dir_row_t;

	typedef struct packed {
		logic [BYTE_W-1:0] b;
		logic              e;
	} text_item_t;

	logic clk = 1'b0;
	logic arst_n;
	logic push;
	logic full;
	logic [BYTE_W-1:0] text_byte;
	logic segment_end;
	logic empty;
	logic pop;
	logic [BYTE_W-1:0] word_char;
	logic [POS_W-1:0] char_position;
	logic last_of_word;
	logic [WNUM_W-1:0] word_ordinal;
	logic [SNUM_W-1:0] segment_number;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic cfg_data;

	// Predictor state: register copies and the tokenizer's own view
	logic keep_long;
	logic space_delim;
	logic [BYTE_W-1:0] word_buf [0:BUF_LEN-1];
	int word_len;
	scan_e scan;
	logic [WNUM_W-1:0] word_cnt;
	logic [SNUM_W-1:0] seg_cnt;

	result_t pending_chars [$];
	dir_row_t dir_tab [$];
	text_item_t text_q [$];

	bit send_idle;
	bit pop_idle;
	int errors;

	always #5 clk = ~clk;

	alnum_word_tokenizer #(
		.WORD_CAP(WORD_CAP)
	) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.text_byte     (text_byte),
		.segment_end   (segment_end),
		.empty         (empty),
		.pop           (pop),
		.word_char     (word_char),
		.char_position (char_position),
		.last_of_word  (last_of_word),
		.word_ordinal  (word_ordinal),
		.segment_number(segment_number),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// ------------------------------------------------------------------
	// Byte classes, C locale
	// ------------------------------------------------------------------
	function automatic logic byte_alnum(input logic [BYTE_W-1:0] b);
		return (b >= CH_DIGIT_0 && b <= CH_DIGIT_9) ||
			(b >= CH_UPPER_A && b <= CH_UPPER_Z) ||
			(b >= CH_LOWER_A && b <= CH_LOWER_Z);
	endfunction

	function automatic logic byte_space(input logic [BYTE_W-1:0] b);
		return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
	endfunction

	function automatic logic [BYTE_W-1:0] fold_case(input logic [BYTE_W-1:0] b);
		if (b >= CH_UPPER_A && b <= CH_UPPER_Z) begin
			return b + CASE_OFFSET;
		end
		return b;
	endfunction

	// Draining an overlong word always uses the alphanumeric class
	function automatic logic drain_cls(input logic [BYTE_W-1:0] b);
		return byte_alnum(b) || b == CH_DOT || b == CH_DASH;
	endfunction

	function automatic logic gather_cls(input logic [BYTE_W-1:0] b);
		return space_delim ? !byte_space(b) : drain_cls(b);
	endfunction

	function automatic logic opens_word(input logic [BYTE_W-1:0] b);
		return space_delim ? !byte_space(b) : byte_alnum(b);
	endfunction

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------
	// Queue the characters of the buffered word; drop one trailing dot.
	// A word left empty consumes no word number.
	function automatic int emit_word();
		int n;
		result_t r;
		n = word_len;
		if (n > 0 && word_buf[n-1] == CH_DOT) begin
			n--;
		end
		for (int k = 0; k < n; k++) begin
			r.ch       = word_buf[k];
			r.pos      = k[POS_W-1:0];
			r.last     = (k == n - 1);
			r.word_num = word_cnt;
			r.seg_num  = seg_cnt;
			pending_chars.push_back(r);
		end
		if (n > 0 && word_cnt != WNUM_MAX) begin
			word_cnt++;
		end
		return n;
	endfunction

	function automatic int close_long_word();
		scan = SCAN_SKIP;
		return keep_long ? emit_word() : 0;
	endfunction

	// Advance the tokenizer by one accepted byte; return the characters queued
	function automatic int tokenize_byte(input logic [BYTE_W-1:0] b, input logic e);
		int n;
		n = 0;
		case (scan)
			SCAN_GATHER: begin
				if (!gather_cls(b)) begin
					n = emit_word();
					scan = SCAN_SKIP;
				end else if (word_len >= BUF_LEN) begin
					// buffer full: keep draining, or end the overlong word here
					if (drain_cls(b) && !e) begin
						scan = SCAN_DRAIN;
					end else begin
						n = close_long_word();
					end
				end else begin
					word_buf[word_len] = fold_case(b);
					word_len++;
					if (e) begin
						n = emit_word();
						scan = SCAN_SKIP;
					end
				end
			end
			SCAN_DRAIN: begin
				if (!(drain_cls(b) && !e)) begin
					n = close_long_word();
				end
			end
			default: begin
				scan = SCAN_SKIP;
				if (opens_word(b)) begin
					word_buf[0] = fold_case(b);
					word_len = 1;
					if (e) begin
						n = emit_word();
					end else begin
						scan = SCAN_GATHER;
					end
				end
			end
		endcase
		if (e) begin
			scan = SCAN_SKIP;
			word_cnt = 1;
			seg_cnt++;
		end
		return n;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	task automatic add_row(input logic cfg_set, input logic keep, input logic spc,
			input logic [BYTE_W-1:0] b, input logic e, input row_chk_e chk,
			input logic [BYTE_W-1:0] ch, input logic [WNUM_W-1:0] wnum,
			input logic [SNUM_W-1:0] snum);
		dir_row_t row;
		row.cfg_set = cfg_set;
		row.keep    = keep;
		row.spc     = spc;
		row.b       = b;
		row.e       = e;
		row.chk     = chk;
		row.ch      = ch;
		row.wnum    = wnum;
		row.snum    = snum;
		dir_tab.push_back(row);
	endtask

	// Hold the byte on the port until the block takes it, then predict
	task automatic feed_byte(input logic [BYTE_W-1:0] b, input logic e, output int n);
		int gap;
		gap = send_idle ? $urandom_range(0, 11) : 0;
		if (gap != 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push        <= 1'b1;
		text_byte   <= b;
		segment_end <= e;
		do @(posedge clk); while (full);
		n = tokenize_byte(b, e);
	endtask

	// Drain every predicted character and let the pipeline go quiet
	task automatic settle();
		push <= 1'b0;
		while (pending_chars.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_cfg(input logic keep, input logic spc);
		cfg_valid <= 1'b1;
		cfg_index <= REG_KEEP_LONG;
		cfg_data  <= keep;
		do @(posedge clk); while (!cfg_ready);
		keep_long = keep;
		cfg_index <= REG_SPACE_DELIM;
		cfg_data  <= spc;
		do @(posedge clk); while (!cfg_ready);
		space_delim = spc;
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [BYTE_W-1:0] word_byte(input logic first);
		int pick;
		logic [BYTE_W-1:0] b;
		pick = $urandom_range(0, 9);
		// in alphanumeric mode a word can only open on a letter or digit
		if (first && !space_delim && pick >= 7) begin
			pick = pick - 7;
		end
		case (pick)
			0, 1, 2: b = CH_LOWER_A + BYTE_W'($urandom_range(0, 25));
			3, 4:    b = CH_UPPER_A + BYTE_W'($urandom_range(0, 25));
			5, 6:    b = CH_DIGIT_0 + BYTE_W'($urandom_range(0, 9));
			7:       b = CH_DOT;
			8:       b = CH_DASH;
			default: begin
				if (space_delim) begin
					do b = BYTE_W'($urandom_range(0, 255)); while (byte_space(b));
				end else begin
					b = CH_LOWER_Z;
				end
			end
		endcase
		return b;
	endfunction

	function automatic logic [BYTE_W-1:0] delim_byte();
		logic [BYTE_W-1:0] b;
		if ($urandom_range(0, 1) == 0) begin
			return CH_SPACE;
		end
		do b = BYTE_W'($urandom_range(0, 255));
		while (space_delim ? !byte_space(b) : drain_cls(b));
		return b;
	endfunction

	// Queue one random sequence: mostly a well-formed word with a random
	// close, sometimes raw noise. A few words run past the buffer length.
	task automatic make_sequence();
		text_item_t it;
		int kind;
		int len;
		int close;
		kind = $urandom_range(0, 9);
		if (kind < 2) begin
			repeat ($urandom_range(1, 4)) begin
				it.b = BYTE_W'($urandom_range(0, 255));
				it.e = ($urandom_range(0, 7) == 0);
				text_q.push_back(it);
			end
		end else begin
			len = (kind < 8) ? $urandom_range(1, 8) : $urandom_range(BUF_LEN - 2, BUF_LEN + 6);
			// 0: segment ends on the last character; 1: delimiter;
			// 2: delimiter that ends the segment; 3: the next word follows
			close = $urandom_range(0, 3);
			for (int i = 0; i < len; i++) begin
				it.b = word_byte(i == 0);
				it.e = (i == len - 1) && (close == 0);
				text_q.push_back(it);
			end
			if (close == 1 || close == 2) begin
				it.b = delim_byte();
				it.e = (close == 2);
				text_q.push_back(it);
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Result checking
	// ------------------------------------------------------------------
	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			errors++;
		end
	endfunction

	// Sample on the edge: pop and empty are the values the block sees
	always @(posedge clk) begin
		result_t want;
		if (arst_n === 1'b1 && pop && !empty) begin
			if (pending_chars.size() == 0) begin
				$display("%0t: character with no prediction, expected none, actual %0h pos %0d",
					$time, word_char, char_position);
				errors++;
			end else begin
				want = pending_chars.pop_front();
				check_field("word_char", 32'(want.ch), 32'(word_char));
				check_field("char_position", 32'(want.pos), 32'(char_position));
				check_field("last_of_word", 32'(want.last), 32'(last_of_word));
				check_field("word_ordinal", want.word_num, word_ordinal);
				check_field("segment_number", 32'(want.seg_num), 32'(segment_number));
			end
		end
	end

	// Receiver: while pop_idle is set, draw a random stall before every character
	initial begin
		int gap;
		pop <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			gap = pop_idle ? $urandom_range(0, 11) : 0;
			if (gap != 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		text_item_t it;
		int n;
		int sent;
		errors      = 0;
		send_idle   = 1'b1;
		pop_idle    = 1'b1;
		keep_long   = 1'b0;
		space_delim = 1'b0;
		word_len    = 0;
		scan        = SCAN_SKIP;
		word_cnt    = 1;
		seg_cnt     = '0;
		arst_n      <= 1'b0;
		push        <= 1'b0;
		text_byte   <= '0;
		segment_end <= 1'b0;
		cfg_valid   <= 1'b0;
		cfg_index   <= REG_KEEP_LONG;
		cfg_data    <= 1'b0;

		// Directed table, reset registers first, then space-delimited with
		// long words kept. Typed rows give a value readable at a glance.
		// one-character word at segment end
		add_row(1'b0, 1'b0, 1'b0, "A", 1'b1, CHK_ONE, "a", 32'd1, 16'd0);
		add_row(1'b0, 1'b0, 1'b0, 8'h00, 1'b0, CHK_NONE, 8'h00, 32'd0, 16'd0);
		add_row(1'b0, 1'b0, 1'b0, 8'hFF, 1'b0, CHK_NONE, 8'h00, 32'd0, 16'd0);
		add_row(1'b0, 1'b0, 1'b0, "Z", 1'b0, CHK_NONE, 8'h00, 32'd0, 16'd0);
		add_row(1'b0, 1'b0, 1'b0, "9", 1'b0, CHK_NONE, 8'h00, 32'd0, 16'd0);
		add_row(1'b0, 1'b0, 1'b0, CH_DASH, 1'b0, CHK_NONE, 8'h00, 32'd0, 16'd0);
		add_row(1'b0, 1'b0, 1'b0, CH_DOT, 1'b0, CHK_NONE, 8'h00, 32'd0, 16'd0);
		// delimiter closes, dot stripped
		add_row(1'b0, 1'b0, 1'b0, CH_SPACE, 1'b0, CHK_MODEL, 8'h00, 32'd0, 16'd0);
		add_row(1'b0, 1'b0, 1'b0, "a", 1'b0, CHK_NONE, 8'h00, 32'd0, 16'd0);
		// word ends on segment end
		add_row(1'b0, 1'b0, 1'b0, CH_DOT, 1'b1, CHK_MODEL, 8'h00, 32'd0, 16'd0);
		add_row(1'b0, 1'b0, 1'b0, "0", 1'b1, CHK_ONE, "0", 32'd1, 16'd2);
		// dot cannot open a word
		add_row(1'b0, 1'b0, 1'b0, CH_DOT, 1'b0, CHK_NONE, 8'h00, 32'd0, 16'd0);
		add_row(1'b1, 1'b1, 1'b1, CH_DOT, 1'b0, CHK_NONE, 8'h00, 32'd0, 16'd0);
		// lone dot: empty word
		add_row(1'b0, 1'b1, 1'b1, CH_SPACE, 1'b0, CHK_NONE, 8'h00, 32'd0, 16'd0);
		add_row(1'b0, 1'b1, 1'b1, "!", 1'b1, CHK_ONE, "!", 32'd1, 16'd3);
		add_row(1'b0, 1'b1, 1'b1, 8'h80, 1'b0, CHK_NONE, 8'h00, 32'd0, 16'd0);
		add_row(1'b0, 1'b1, 1'b1, "Q", 1'b0, CHK_NONE, 8'h00, 32'd0, 16'd0);
		add_row(1'b0, 1'b1, 1'b1, CH_CR, 1'b0, CHK_MODEL, 8'h00, 32'd0, 16'd0);
		add_row(1'b0, 1'b1, 1'b1, CH_TAB, 1'b1, CHK_NONE, 8'h00, 32'd0, 16'd0);
		add_row(1'b0, 1'b1, 1'b1, "X", 1'b0, CHK_NONE, 8'h00, 32'd0, 16'd0);
		add_row(1'b0, 1'b1, 1'b1, CH_SPACE, 1'b1, CHK_MODEL, 8'h00, 32'd0, 16'd0);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_cfg(1'b0, 1'b0);

		foreach (dir_tab[i]) begin
			if (dir_tab[i].cfg_set) begin
				settle();
				write_cfg(dir_tab[i].keep, dir_tab[i].spc);
			end
			feed_byte(dir_tab[i].b, dir_tab[i].e, n);
			if (dir_tab[i].chk != CHK_MODEL) begin
				// replace the prediction with the typed value
				repeat (n) void'(pending_chars.pop_back());
				if (dir_tab[i].chk == CHK_ONE) begin
					pending_chars.push_back('{ch: dir_tab[i].ch, pos: '0, last: 1'b1,
						word_num: dir_tab[i].wnum, seg_num: dir_tab[i].snum});
				end
			end
		end

		// Random phases through every register setting; vary which side idles
		for (int p = 0; p < RAND_PHASES; p++) begin
			settle();
			write_cfg(p[0], p[1]);
			send_idle = (p % 3) != 1;
			pop_idle  = (p % 3) != 2;
			sent = 0;
			while (sent < RAND_PHASE_ITEMS) begin
				if (text_q.size() == 0) begin
					make_sequence();
				end
				it = text_q.pop_front();
				feed_byte(it.b, it.e, n);
				sent++;
			end
			text_q.delete();
			// close any open word so the registers change on an idle block
			feed_byte(CH_SPACE, 1'b1, n);
		end

		settle();
		if (errors == 0) begin
			$display("tb_alnum_word_tokenizer: PASS");
		end else begin
			$display("tb_alnum_word_tokenizer: FAIL");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run
	initial begin
		#8_000_000;
		$display("tb_alnum_word_tokenizer: FAIL");
		$finish;
	end

endmodule

@@ files.f @@
design/awt_pkg.sv
design/awt_ram.sv
design/awt_front.sv
design/awt_word_q.sv
design/awt_back.sv
design/alnum_word_tokenizer.sv
tb/tb_alnum_word_tokenizer.sv
